/* rtl/tsa_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, lane types and the arctangent table of the triangle solid angle block.
package tsa_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int ANGLE_FRAC_DEF = 24;
	localparam int OUT_W = 28;

	localparam int VEC_LIMIT = 19;
	localparam int VEC_W = VEC_LIMIT + 1;
	localparam int PR_W = 2 * VEC_LIMIT + 1;
	localparam int CROSS_W = 2 * VEC_LIMIT + 2;
	localparam int DOT_W = 2 * VEC_LIMIT + 3;
	localparam int SQ_W = 2 * VEC_LIMIT + 2;
	localparam int LEN_W = SQ_W / 2;
	localparam int TRM_W = DOT_W + LEN_W;
	localparam int DET_W = 61;
	localparam int DIV_W = 63;

	localparam int ATAN_LIMIT = 40;
	localparam int NRM_W = ATAN_LIMIT + 1;
	localparam int CW = ATAN_LIMIT + 4;
	localparam int ZW = 34;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef logic signed [VEC_W-1:0] vec_t;

	typedef struct packed {
		logic signed [DET_W-1:0] det;
		logic signed [DOT_W-1:0] dab;
		logic signed [DOT_W-1:0] dbc;
		logic signed [DOT_W-1:0] dca;
	} geo_side_t;

	typedef struct packed {
		logic [LEN_W+2:0] rem;
		logic [LEN_W-1:0] root;
		logic [SQ_W-1:0]  xr;
	} sq_lane_t;

	function automatic logic [ZW-1:0] atan_rom(input logic [4:0] idx);
		logic [ZW-1:0] r;
		case (idx)
			5'd0:  r = 34'h03243F6A8;
			5'd1:  r = 34'h01DAC6705;
			5'd2:  r = 34'h00FADBAFC;
			5'd3:  r = 34'h007F56EA6;
			5'd4:  r = 34'h003FEAB76;
			5'd5:  r = 34'h001FFD55B;
			5'd6:  r = 34'h000FFFAAA;
			5'd7:  r = 34'h0007FFF55;
			5'd8:  r = 34'h0003FFFEA;
			5'd9:  r = 34'h0001FFFFD;
			5'd10: r = 34'h0000FFFFF;
			5'd11: r = 34'h00007FFFF;
			5'd12: r = 34'h00003FFFF;
			5'd13: r = 34'h00001FFFF;
			5'd14: r = 34'h00000FFFF;
			5'd15: r = 34'h000007FFF;
			5'd16: r = 34'h000003FFF;
			5'd17: r = 34'h000001FFF;
			5'd18: r = 34'h000000FFF;
			5'd19: r = 34'h0000007FF;
			5'd20: r = 34'h0000003FF;
			5'd21: r = 34'h0000001FF;
			5'd22: r = 34'h0000000FF;
			5'd23: r = 34'h00000007F;
			5'd24: r = 34'h00000003F;
			5'd25: r = 34'h00000001F;
			5'd26: r = 34'h00000000F;
			5'd27: r = 34'h000000008;
			5'd28: r = 34'h000000004;
			5'd29: r = 34'h000000002;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

/* rtl/triangle_solid_angle.sv */
`timescale 1ns / 1ps
// Top level of the triangle solid angle block.
//
// Streams point-triangle requests and returns the signed solid angle
// 2*atan2(a.(b x c), |a||b||c| + (a.b)|c| + (b.c)|a| + (c.a)|b|) in signed
// Q3.24 radians, where a, b, c are the vertices minus the point. One request
// enters every cycle unless out_ready holds back a full pipeline. The stages
// run through vector forming and normalization, products and sums, the
// two-digit-per-stage square roots, the denominator, and atan2: scaling,
// quarter-turn pre-rotation, one CORDIC iteration per stage and the rounding
// stage. Every stage has its own valid bit and advances when it is empty or
// its successor advances, so bubbles close up and the pipeline keeps accepting
// requests while a finished result waits on out_ready. A degenerate case with
// both atan2 arguments zero returns 0.
module triangle_solid_angle import tsa_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic signed [COORD_BITS-1:0] third_x,
	input  logic signed [COORD_BITS-1:0] third_y,
	input  logic signed [COORD_BITS-1:0] third_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OUT_W-1:0] signed_angle
);
	logic signed [COORD_BITS-1:0] pt [3];
	logic signed [COORD_BITS-1:0] vtx [9];
	vec_t vec [9];
	logic vec_valid, geo_ready, geo_valid, atan_ready;
	logic signed [DET_W-1:0] det;
	logic signed [DIV_W-1:0] div;

	// gather the request into point and vertex arrays
	assign pt = '{point_x, point_y, point_z};
	assign vtx = '{first_x, first_y, first_z, second_x, second_y, second_z,
		third_x, third_y, third_z};

	// vertex vectors, scaled together so the largest component sits just under 2^19
	tsa_vec #(
		.COORD_BITS(COORD_BITS)
	) u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pt       (pt),
		.vtx      (vtx),
		.out_valid(vec_valid),
		.out_ready(geo_ready),
		.vec      (vec)
	);

	// triple product and denominator
	tsa_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vec_valid),
		.in_ready (geo_ready),
		.vec      (vec),
		.out_valid(geo_valid),
		.out_ready(atan_ready),
		.det      (det),
		.div      (div)
	);

	// angle, doubled and rounded to the output format
	tsa_atan #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_atan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (geo_valid),
		.in_ready (atan_ready),
		.det      (det),
		.div      (div),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.angle    (signed_angle)
	);
endmodule

/* rtl/tsa_vec.sv */
`timescale 1ns / 1ps
// Vertex vectors relative to the point, with common block-floating normalization.
module tsa_vec import tsa_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_BITS-1:0] pt [3],
	input  logic signed [COORD_BITS-1:0] vtx [9],
	output logic out_valid,
	input  logic out_ready,
	output vec_t vec [9]
);
	localparam int NS = 3;
	localparam int DW = COORD_BITS + 1;
	localparam int MW = (DW > VEC_W) ? DW : VEC_W;
	localparam int PW = $clog2(DW);
	localparam int SHW = $clog2(MW + 1);

	logic [NS-1:0] vld_s;
	logic [NS:0] en;
	logic [NS-1:0] vprev;

	logic signed [DW-1:0] diff_s1 [9];
	logic [DW-1:0] mag [9];
	logic [DW-1:0] orm;
	logic [PW-1:0] pos;
	logic rsh;
	logic [SHW-1:0] sh;
	logic [DW-1:0] mag_s2 [9];
	logic [8:0] neg_s2;
	logic rsh_s2;
	logic [SHW-1:0] sh_s2;
	vec_t vec_s3 [9];
	logic [MW-1:0] shm [9];

	assign en[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = ~vld_s[k] | en[k+1];
	end
	assign vprev = {vld_s[NS-2:0], in_valid};
	assign in_ready = en[0];
	assign out_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vprev[k];
				end
			end
		end
	end

	// largest magnitude shares its leading one with the OR of all magnitudes
	always_comb begin
		orm = '0;
		pos = '0;
		for (int j = 0; j < 9; j++) begin
			mag[j] = diff_s1[j][DW-1] ? DW'(-diff_s1[j]) : DW'(diff_s1[j]);
			orm = orm | mag[j];
		end
		for (int i = 0; i < DW; i++) begin
			if (orm[i]) begin
				pos = PW'(i);
			end
		end
		if (int'(pos) >= VEC_LIMIT) begin
			rsh = 1'b1;
			sh = SHW'(int'(pos) - (VEC_LIMIT - 1));
		end else begin
			rsh = 1'b0;
			sh = SHW'((VEC_LIMIT - 1) - int'(pos));
		end
		for (int j = 0; j < 9; j++) begin
			shm[j] = rsh_s2 ? (MW'(mag_s2[j]) >> sh_s2) : (MW'(mag_s2[j]) << sh_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 9; j++) begin
				diff_s1[j] <= DW'(vtx[j]) - DW'(pt[j % 3]);
			end
		end
		if (en[1]) begin
			for (int j = 0; j < 9; j++) begin
				mag_s2[j] <= mag[j];
				neg_s2[j] <= diff_s1[j][DW-1];
			end
			rsh_s2 <= rsh;
			sh_s2 <= sh;
		end
		if (en[2]) begin
			for (int j = 0; j < 9; j++) begin
				vec_s3[j] <= neg_s2[j] ? -vec_t'(shm[j][VEC_W-1:0]) : vec_t'(shm[j][VEC_W-1:0]);
			end
		end
	end

	assign vec = vec_s3;
endmodule

/* rtl/tsa_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root of three lengths, two digits a stage.
module tsa_sqrt import tsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [SQ_W-1:0] rad [3],
	input  geo_side_t side_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [LEN_W-1:0] len [3],
	output geo_side_t side_out
);
	localparam int NS = LEN_W / 2;

	function automatic sq_lane_t sq_step(input sq_lane_t a);
		sq_lane_t r;
		logic [LEN_W+2:0] cur;
		logic [LEN_W+2:0] tst;
		cur = {a.rem[LEN_W:0], a.xr[SQ_W-1 -: 2]};
		tst = {1'b0, a.root, 2'b01};
		r.xr = a.xr << 2;
		if (cur >= tst) begin
			r.rem = cur - tst;
			r.root = {a.root[LEN_W-2:0], 1'b1};
		end else begin
			r.rem = cur;
			r.root = {a.root[LEN_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [NS-1:0] vld_s;
	logic [NS:0] en;
	logic [NS-1:0] vprev;
	sq_lane_t ln_s [NS][3];
	geo_side_t sd_s [NS];
	sq_lane_t init [3];

	assign en[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = ~vld_s[k] | en[k+1];
	end
	assign vprev = {vld_s[NS-2:0], in_valid};
	assign in_ready = en[0];
	assign out_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vprev[k];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			init[l].rem = '0;
			init[l].root = '0;
			init[l].xr = rad[l];
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_st
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int l = 0; l < 3; l++) begin
						ln_s[k][l] <= sq_step(sq_step(init[l]));
					end
					sd_s[k] <= side_in;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) begin
					for (int l = 0; l < 3; l++) begin
						ln_s[k][l] <= sq_step(sq_step(ln_s[k-1][l]));
					end
					sd_s[k] <= sd_s[k-1];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			len[l] = ln_s[NS-1][l].root;
		end
	end
	assign side_out = sd_s[NS-1];
endmodule

/* rtl/tsa_geom.sv */
`timescale 1ns / 1ps
// Triple product, dot products, lengths and the atan2 denominator.
module tsa_geom import tsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  vec_t vec [9],
	output logic out_valid,
	input  logic out_ready,
	output logic signed [DET_W-1:0] det,
	output logic signed [DIV_W-1:0] div
);
	localparam int NF = 4;
	localparam int NB = 3;

	logic [NF-1:0] vf_s;
	logic [NF:0] ef;
	logic [NF-1:0] vfp;
	logic [NB-1:0] vb_s;
	logic [NB:0] eb;
	logic [NB-1:0] vbp;

	logic sq_in_ready, sq_out_valid;
	logic [LEN_W-1:0] len [3];
	geo_side_t side_in, side_out;

	logic signed [PR_W-1:0] xp_s1 [6];
	logic signed [PR_W-1:0] pab_s1 [3], pbc_s1 [3], pca_s1 [3];
	logic signed [PR_W-1:0] qa_s1 [3], qb_s1 [3], qc_s1 [3];
	vec_t a_s1 [3], a_s2 [3];
	logic signed [CROSS_W-1:0] cr_s2 [3];
	logic signed [DOT_W-1:0] dab_s2, dbc_s2, dca_s2, dab_s3, dbc_s3, dca_s3;
	logic signed [DOT_W-1:0] dab_s4, dbc_s4, dca_s4;
	logic [SQ_W-1:0] sq_s2 [3], sq_s3 [3], sq_s4 [3];
	logic signed [DET_W-1:0] dt_s3 [3];
	logic signed [DET_W-1:0] det_s4, det_s5, det_s6, det_s7;

	logic [2*LEN_W-1:0] lab_s5;
	logic [LEN_W-1:0] lc_s5;
	logic signed [TRM_W-1:0] tc_s5, ta_s5, tb_s5;
	logic [3*LEN_W-1:0] labc_s6;
	logic signed [DIV_W-1:0] ts_s6, div_s7;

	// front stages
	assign ef[NF] = sq_in_ready;
	for (genvar k = 0; k < NF; k++) begin : g_ef
		assign ef[k] = ~vf_s[k] | ef[k+1];
	end
	assign vfp = {vf_s[NF-2:0], in_valid};
	assign in_ready = ef[0];

	// back stages
	assign eb[NB] = out_ready;
	for (genvar k = 0; k < NB; k++) begin : g_eb
		assign eb[k] = ~vb_s[k] | eb[k+1];
	end
	assign vbp = {vb_s[NB-2:0], sq_out_valid};
	assign out_valid = vb_s[NB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_s <= '0;
			vb_s <= '0;
		end else begin
			for (int k = 0; k < NF; k++) begin
				if (ef[k]) begin
					vf_s[k] <= vfp[k];
				end
			end
			for (int k = 0; k < NB; k++) begin
				if (eb[k]) begin
					vb_s[k] <= vbp[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ef[0]) begin
			xp_s1[0] <= vec[4] * vec[8];
			xp_s1[1] <= vec[5] * vec[7];
			xp_s1[2] <= vec[5] * vec[6];
			xp_s1[3] <= vec[3] * vec[8];
			xp_s1[4] <= vec[3] * vec[7];
			xp_s1[5] <= vec[4] * vec[6];
			for (int i = 0; i < 3; i++) begin
				pab_s1[i] <= vec[i] * vec[3+i];
				pbc_s1[i] <= vec[3+i] * vec[6+i];
				pca_s1[i] <= vec[6+i] * vec[i];
				qa_s1[i] <= vec[i] * vec[i];
				qb_s1[i] <= vec[3+i] * vec[3+i];
				qc_s1[i] <= vec[6+i] * vec[6+i];
				a_s1[i] <= vec[i];
			end
		end
		if (ef[1]) begin
			for (int i = 0; i < 3; i++) begin
				cr_s2[i] <= CROSS_W'(xp_s1[2*i]) - CROSS_W'(xp_s1[2*i+1]);
				a_s2[i] <= a_s1[i];
			end
			dab_s2 <= DOT_W'(pab_s1[0]) + DOT_W'(pab_s1[1]) + DOT_W'(pab_s1[2]);
			dbc_s2 <= DOT_W'(pbc_s1[0]) + DOT_W'(pbc_s1[1]) + DOT_W'(pbc_s1[2]);
			dca_s2 <= DOT_W'(pca_s1[0]) + DOT_W'(pca_s1[1]) + DOT_W'(pca_s1[2]);
			sq_s2[0] <= SQ_W'($unsigned(qa_s1[0])) + SQ_W'($unsigned(qa_s1[1]))
				+ SQ_W'($unsigned(qa_s1[2]));
			sq_s2[1] <= SQ_W'($unsigned(qb_s1[0])) + SQ_W'($unsigned(qb_s1[1]))
				+ SQ_W'($unsigned(qb_s1[2]));
			sq_s2[2] <= SQ_W'($unsigned(qc_s1[0])) + SQ_W'($unsigned(qc_s1[1]))
				+ SQ_W'($unsigned(qc_s1[2]));
		end
		if (ef[2]) begin
			for (int i = 0; i < 3; i++) begin
				dt_s3[i] <= a_s2[i] * cr_s2[i];
			end
			dab_s3 <= dab_s2;
			dbc_s3 <= dbc_s2;
			dca_s3 <= dca_s2;
			sq_s3 <= sq_s2;
		end
		if (ef[3]) begin
			det_s4 <= dt_s3[0] + dt_s3[1] + dt_s3[2];
			dab_s4 <= dab_s3;
			dbc_s4 <= dbc_s3;
			dca_s4 <= dca_s3;
			sq_s4 <= sq_s3;
		end
	end

	assign side_in = '{det: det_s4, dab: dab_s4, dbc: dbc_s4, dca: dca_s4};

	tsa_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vf_s[NF-1]),
		.in_ready (sq_in_ready),
		.rad      (sq_s4),
		.side_in  (side_in),
		.out_valid(sq_out_valid),
		.out_ready(eb[0]),
		.len      (len),
		.side_out (side_out)
	);

	always_ff @(posedge clk) begin
		if (eb[0]) begin
			lab_s5 <= (2*LEN_W)'(len[0]) * (2*LEN_W)'(len[1]);
			lc_s5 <= len[2];
			tc_s5 <= side_out.dab * $signed({1'b0, len[2]});
			ta_s5 <= side_out.dbc * $signed({1'b0, len[0]});
			tb_s5 <= side_out.dca * $signed({1'b0, len[1]});
			det_s5 <= side_out.det;
		end
		if (eb[1]) begin
			labc_s6 <= (3*LEN_W)'(lab_s5) * (3*LEN_W)'(lc_s5);
			ts_s6 <= DIV_W'(tc_s5) + DIV_W'(ta_s5) + DIV_W'(tb_s5);
			det_s6 <= det_s5;
		end
		if (eb[2]) begin
			div_s7 <= DIV_W'($signed({1'b0, labc_s6})) + ts_s6;
			det_s7 <= det_s6;
		end
	end

	assign det = det_s7;
	assign div = div_s7;
endmodule

/* rtl/tsa_atan.sv */
`timescale 1ns / 1ps
// Pipelined full-quadrant CORDIC atan2 with output doubling and rounding.
module tsa_atan import tsa_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [DET_W-1:0] det,
	input  logic signed [DIV_W-1:0] div,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [OUT_W-1:0] angle
);
	localparam int NT = 4 + CORDIC_STEPS + 1;
	localparam int PW = $clog2(DIV_W);
	localparam int SHW = $clog2(DIV_W + 1);
	localparam int RS = (ANGLE_FRAC_BITS >= 30) ? 0 : 30 - ANGLE_FRAC_BITS;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} cs_t;

	logic [NT-1:0] vld_s;
	logic [NT:0] en;
	logic [NT-1:0] vprev;

	logic [DIV_W-1:0] xm_s1, ym_s1, xm_s2, ym_s2;
	logic xn_s1, yn_s1, xn_s2, yn_s2;
	logic [DIV_W-1:0] orm;
	logic [PW-1:0] pos;
	logic rsh, rsh_s2, zero_s2, zero_s3;
	logic [SHW-1:0] sh, sh_s2;
	logic [DIV_W-1:0] xsh, ysh;
	logic signed [NRM_W-1:0] x_s3, y_s3;
	cs_t st4;
	cs_t cs_s4;
	cs_t cs_s [CORDIC_STEPS];
	logic signed [ZW-1:0] zc;
	logic signed [ZW:0] v;
	logic signed [ZW:0] r;
	logic signed [OUT_W-1:0] ang_s35;

	assign en[NT] = out_ready;
	for (genvar k = 0; k < NT; k++) begin : g_en
		assign en[k] = ~vld_s[k] | en[k+1];
	end
	assign vprev = {vld_s[NT-2:0], in_valid};
	assign in_ready = en[0];
	assign out_valid = vld_s[NT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NT; k++) begin
				if (en[k]) begin
					vld_s[k] <= vprev[k];
				end
			end
		end
	end

	always_comb begin
		orm = xm_s1 | ym_s1;
		pos = '0;
		for (int i = 0; i < DIV_W; i++) begin
			if (orm[i]) begin
				pos = PW'(i);
			end
		end
		if (int'(pos) >= ATAN_LIMIT) begin
			rsh = 1'b1;
			sh = SHW'(int'(pos) - (ATAN_LIMIT - 1));
		end else begin
			rsh = 1'b0;
			sh = SHW'((ATAN_LIMIT - 1) - int'(pos));
		end
		xsh = rsh_s2 ? (xm_s2 >> sh_s2) : (xm_s2 << sh_s2);
		ysh = rsh_s2 ? (ym_s2 >> sh_s2) : (ym_s2 << sh_s2);

		// left half-plane: pre-rotate by a quarter turn
		st4.zero = zero_s3;
		if (x_s3 < 0) begin
			if (y_s3 >= 0) begin
				st4.x = CW'(y_s3);
				st4.y = -CW'(x_s3);
				st4.z = HALF_PI_Q30;
			end else begin
				st4.x = -CW'(y_s3);
				st4.y = CW'(x_s3);
				st4.z = -HALF_PI_Q30;
			end
		end else begin
			st4.x = CW'(x_s3);
			st4.y = CW'(y_s3);
			st4.z = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ym_s1 <= det[DET_W-1] ? DIV_W'(-DIV_W'(det)) : DIV_W'(det);
			xm_s1 <= div[DIV_W-1] ? DIV_W'(-div) : DIV_W'(div);
			yn_s1 <= det[DET_W-1];
			xn_s1 <= div[DIV_W-1];
		end
		if (en[1]) begin
			xm_s2 <= xm_s1;
			ym_s2 <= ym_s1;
			xn_s2 <= xn_s1;
			yn_s2 <= yn_s1;
			rsh_s2 <= rsh;
			sh_s2 <= sh;
			zero_s2 <= (orm == '0);
		end
		if (en[2]) begin
			x_s3 <= xn_s2 ? -$signed(xsh[NRM_W-1:0]) : $signed(xsh[NRM_W-1:0]);
			y_s3 <= yn_s2 ? -$signed(ysh[NRM_W-1:0]) : $signed(ysh[NRM_W-1:0]);
			zero_s3 <= zero_s2;
		end
		if (en[3]) begin
			cs_s4 <= st4;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		cs_t src;
		cs_t nxt;
		if (k == 0) begin : g_first
			assign src = cs_s4;
		end else begin : g_next
			assign src = cs_s[k-1];
		end
		always_comb begin
			nxt.zero = src.zero;
			if (!src.y[CW-1]) begin
				nxt.x = src.x + (src.y >>> k);
				nxt.y = src.y - (src.x >>> k);
				nxt.z = src.z + $signed(atan_rom(5'(k)));
			end else begin
				nxt.x = src.x - (src.y >>> k);
				nxt.y = src.y + (src.x >>> k);
				nxt.z = src.z - $signed(atan_rom(5'(k)));
			end
		end
		always_ff @(posedge clk) begin
			if (en[4+k]) begin
				cs_s[k] <= nxt;
			end
		end
	end

	always_comb begin
		zc = cs_s[CORDIC_STEPS-1].z;
		if (zc > PI_Q30) begin
			zc = PI_Q30;
		end
		if (zc < -PI_Q30) begin
			zc = -PI_Q30;
		end
		v = (ZW+1)'(zc) <<< 1;
	end

	if (RS == 0) begin : g_noround
		assign r = v;
	end else begin : g_round
		localparam logic [ZW:0] HALF_LSB = (ZW+1)'(1) << (RS - 1);
		logic [ZW:0] av, am;
		always_comb begin
			av = v[ZW] ? $unsigned(-v) : $unsigned(v);
			am = (av + HALF_LSB) >> RS;
			r = v[ZW] ? -$signed(am) : $signed(am);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NT-1]) begin
			ang_s35 <= cs_s[CORDIC_STEPS-1].zero ? '0 : r[OUT_W-1:0];
		end
	end

	assign angle = ang_s35;
endmodule

/* sim/triangle_solid_angle_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the triangle solid angle block.
module triangle_solid_angle_tb;
	import tsa_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM = 1530;
	localparam int N_DIRECTED = 14;
	localparam logic signed [OUT_W-1:0] FULL_TURN_Q24 = 28'sd105414357;
	localparam longint CMAX = 64'sd8388607;
	localparam longint CMIN = -64'sd8388608;
	localparam longint ONE = 64'sd4096;

	typedef longint coord_row_t [12];

	typedef struct {
		logic signed [OUT_W-1:0] angle;
		bit                      has_typed;
		logic signed [OUT_W-1:0] typed;
	} angle_entry_t;

	typedef struct {
		coord_row_t              crd;
		bit                      has_typed;
		logic signed [OUT_W-1:0] typed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] crd_port [12];
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] signed_angle;

	angle_entry_t pending_angles [$];
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	stim_row_t directed [N_DIRECTED];

	initial begin
		for (int i = 0; i < 12; i++)
			crd_port[i] = '0;
	end

	triangle_solid_angle dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(crd_port[0]), .point_y(crd_port[1]), .point_z(crd_port[2]),
		.first_x(crd_port[3]), .first_y(crd_port[4]), .first_z(crd_port[5]),
		.second_x(crd_port[6]), .second_y(crd_port[7]), .second_z(crd_port[8]),
		.third_x(crd_port[9]), .third_y(crd_port[10]), .third_z(crd_port[11]),
		.out_valid(out_valid), .out_ready(out_ready), .signed_angle(signed_angle)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scale n values by one common shift so the largest magnitude lands just below 2^lim.
	function automatic void scale_common(inout longint v [9], input int n, input int lim);
		longint m;
		int s;
		m = 0;
		s = 0;
		for (int i = 0; i < n; i++)
			if ((v[i] < 0 ? -v[i] : v[i]) > m)
				m = v[i] < 0 ? -v[i] : v[i];
		if (m == 0)
			return;
		if (m >= (64'sd1 << lim)) begin
			while ((m >> s) >= (64'sd1 << lim))
				s++;
			for (int i = 0; i < n; i++)
				v[i] = v[i] < 0 ? -((-v[i]) >> s) : (v[i] >> s);
		end else begin
			while ((m << (s + 1)) < (64'sd1 << lim))
				s++;
			for (int i = 0; i < n; i++)
				v[i] = v[i] <<< s;
		end
	endfunction

	function automatic longint floor_root(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// Vectoring CORDIC atan2 in Q2.30, clamped to a half turn.
	function automatic longint atan2_q30(input longint y, input longint x);
		longint pr [9];
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		pr = '{default: 0};
		pr[0] = x;
		pr[1] = y;
		scale_common(pr, 2, ATAN_LIMIT);
		x = pr[0];
		y = pr[1];
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI_Q30;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI_Q30;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(atan_rom(5'(i)));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(atan_rom(5'(i)));
			end
		end
		if (z > PI_Q30) z = PI_Q30;
		if (z < -PI_Q30) z = -PI_Q30;
		return z;
	endfunction

	function automatic logic signed [OUT_W-1:0] solid_angle_q24(input coord_row_t crd);
		longint d [9];
		longint det, dab, dbc, dca, la, lb, lc, dv, v, m;
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				d[k*3+i] = longint'(CB'(crd[3+k*3+i])) - longint'(CB'(crd[i]));
		for (int k = 0; k < 9; k++)
			d[k] = longint'($signed(CB'(crd[3+k]))) - longint'($signed(CB'(crd[k%3])));
		scale_common(d, 9, VEC_LIMIT);
		det = d[0] * (d[4] * d[8] - d[5] * d[7])
		    + d[1] * (d[5] * d[6] - d[3] * d[8])
		    + d[2] * (d[3] * d[7] - d[4] * d[6]);
		dab = d[0] * d[3] + d[1] * d[4] + d[2] * d[5];
		dbc = d[3] * d[6] + d[4] * d[7] + d[5] * d[8];
		dca = d[6] * d[0] + d[7] * d[1] + d[8] * d[2];
		la = floor_root(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
		lb = floor_root(d[3] * d[3] + d[4] * d[4] + d[5] * d[5]);
		lc = floor_root(d[6] * d[6] + d[7] * d[7] + d[8] * d[8]);
		dv = la * lb * lc + dab * lc + dbc * la + dca * lb;
		v = 2 * atan2_q30(det, dv);
		// Round from 30 to 24 fraction bits, half away from zero.
		m = ((v < 0 ? -v : v) + (64'sd1 << (30 - ANGLE_FRAC_DEF - 1))) >> (30 - ANGLE_FRAC_DEF);
		return OUT_W'(v < 0 ? -m : m);
	endfunction

	// Offer one request, hold it until accepted, then log its predicted angle.
	task automatic send_request(input coord_row_t crd, input bit has_typed,
	                            input logic signed [OUT_W-1:0] typed);
		angle_entry_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		for (int i = 0; i < 12; i++)
			crd_port[i] <= CB'(crd[i]);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		e.angle = solid_angle_q24(crd);
		e.has_typed = has_typed;
		e.typed = typed;
		pending_angles = {pending_angles, e};
		requests_sent++;
	endtask

	function automatic longint rand_coord(input int mode);
		case (mode)
			0: return longint'($signed(24'($urandom)));
			1: return longint'($urandom_range(8191)) - 4096;
			2: return $urandom_range(1) ? CMAX : CMIN;
			default: return longint'($urandom_range(255)) - 128;
		endcase
	endfunction

	// Build a random query: wide or narrow spread, sometimes a degenerate triangle
	// or a point lying in the triangle's plane.
	task automatic random_request();
		coord_row_t crd;
		int mode, shape;
		mode = $urandom_range(3);
		shape = $urandom_range(9);
		for (int i = 0; i < 12; i++)
			crd[i] = rand_coord(mode);
		if (shape == 0) begin
			for (int i = 0; i < 3; i++)
				crd[9+i] = crd[6+i];
		end else if (shape == 1) begin
			crd[2] = 0; crd[5] = 0; crd[8] = 0; crd[11] = 0;
		end else if (shape == 2) begin
			for (int i = 0; i < 3; i++)
				crd[3+i] = crd[i];
		end
		send_request(crd, 1'b0, '0);
	endtask

	// Receiver: random stalls per phase, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each returned angle with the oldest prediction.
	always @(posedge clk) begin
		angle_entry_t e;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d with nothing pending", signed_angle);
			end else begin
				e = pending_angles.pop_front();
				if (signed_angle !== e.angle || (e.has_typed && signed_angle !== e.typed)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: signed_angle expected %0d (typed %0d) got %0d",
						         results_seen, e.angle, e.typed, signed_angle);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
			         pending_angles.size());
			$display("triangle_solid_angle_tb failed");
			$finish;
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_angles.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		coord_row_t z;
		z = '{default: 0};
		// Directed rows: zeros, coincident points, extremes, in-plane point.
		directed[0] = '{z, 1'b1, 28'sd0};
		directed[1] = '{'{default: CMAX}, 1'b1, 28'sd0};
		directed[2] = '{'{default: CMIN}, 1'b1, 28'sd0};
		directed[3] = '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
		                 CMAX, CMAX, CMAX}, 1'b1, 28'sd0};
		directed[4] = '{'{0, 0, 0, ONE, 0, 0, -ONE, ONE, 0, -ONE, -ONE, 0},
		                1'b1, FULL_TURN_Q24};
		directed[5] = '{'{0, 0, 0, ONE, 0, 0, -ONE, -ONE, 0, -ONE, ONE, 0},
		                1'b1, FULL_TURN_Q24};
		directed[6] = '{'{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b0, '0};
		directed[7] = '{'{0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, ONE, 0}, 1'b0, '0};
		directed[8] = '{'{CMAX, CMAX, CMAX, CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN},
		                1'b0, '0};
		directed[9] = '{'{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN,
		                 CMIN, CMIN, CMAX}, 1'b0, '0};
		directed[10] = '{'{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, '0};
		directed[11] = '{'{0, 0, 0, -1, 0, 0, 0, -1, 0, 0, 0, -1}, 1'b0, '0};
		directed[12] = '{'{0, 0, ONE, ONE, 0, 0, -ONE, ONE, 0, -ONE, -ONE, 0}, 1'b0, '0};
		directed[13] = '{'{0, 0, -ONE, ONE, 0, 0, -ONE, ONE, 0, -ONE, -ONE, 0}, 1'b0, '0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_request(directed[i].crd, directed[i].has_typed, directed[i].typed);

		for (int ph = 0; ph < 4; ph++) begin
			// Pause until every pending result is back before changing pace.
			drain();
			send_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 35 : 0;
			recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 35 : 0;
			if (ph == 0)
				hold_cycles = 300;
			for (int n = 0; n < N_RANDOM / 4; n++)
				random_request();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d requests (directed extremes, degenerate and in-plane cases,",
		         requests_sent);
		$display("random spreads) under four pacing phases and a long output hold-off");
		if (mismatches == 0 && pending_angles.size() == 0)
			$display("triangle_solid_angle_tb passed");
		else
			$display("triangle_solid_angle_tb failed");
		$finish;
	end
endmodule
